### rtl/wildcard_star_regex_matcher_assert.svh
// Assertion macros shared by the matcher checker.
`ifndef WILDCARD_STAR_REGEX_MATCHER_ASSERT_SVH
`define WILDCARD_STAR_REGEX_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define WCSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define WCSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wcsm_pkg.sv
// Types and constants of the wildcard star regex matcher.
package wcsm_pkg;

	localparam int unsigned PATTERN_MAX = 32;
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] DOT_BYTE = 8'h2E;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_RESTART = 2'd2,
		OP_TEXT    = 2'd3
	} op_t;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} result_t;

	// Signals every cell sees alike.
	typedef struct packed {
		logic       restart;
		logic       consume;
		logic [7:0] data_byte;
	} bcast_t;

	// Signals decoded for one cell from its position and the pattern length.
	typedef struct packed {
		logic origin;
		logic live;
		logic live_next;
		logic wr;
		logic nxt_wr;
	} cell_ctl_t;

endpackage

### rtl/wcsm_cell.sv
// One pattern position: its byte, element marks and active bit.
module wcsm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  wcsm_pkg::bcast_t   bcast,
	input  wcsm_pkg::cell_ctl_t ctl,
	input  logic               prev_start,
	input  logic               skip_in,
	input  logic               adv_in,
	output logic               start,
	output logic               skip_out,
	output logic               adv_out,
	output logic               closed
);

	logic [7:0] byte_q;
	logic       start_q;
	logic       starred_q;
	logic       raw_q;
	logic       byte_is_star;
	logic       hit;
	logic       star_ok;

	assign byte_is_star = (bcast.data_byte == wcsm_pkg::STAR_BYTE);
	assign hit = (byte_q == wcsm_pkg::DOT_BYTE) || (byte_q == bcast.data_byte);
	assign star_ok = starred_q & ctl.live_next;

	// The active bit after closure: set directly, or reached by skipping the
	// starred element two positions back.
	assign closed = raw_q | skip_in;
	assign skip_out = closed & star_ok;
	assign adv_out = closed & hit & ctl.live & ~star_ok;
	assign start = start_q;

	// A '*' right after an element that begins at the previous position stars
	// that element; any other byte begins a new element here.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			byte_q <= bcast.data_byte;
			start_q <= ~(byte_is_star & prev_start);
			starred_q <= 1'b0;
		end else if (ctl.nxt_wr && byte_is_star && start_q) begin
			starred_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= ctl.origin;
		end else if (bcast.restart) begin
			raw_q <= ctl.origin;
		end else if (bcast.consume) begin
			raw_q <= (closed & hit & star_ok) | adv_in;
		end
	end

endmodule

### rtl/wildcard_star_regex_matcher.sv
// Top level of the wildcard star regex matcher.
// Whole-string matcher for patterns of literal bytes, '.' and '*' after an element.
// Each pattern position is one cell in a row; text bytes move the active bits
// along the row, and the empty-match closure over starred elements ripples
// through the cells within the same cycle. An item is taken every cycle while
// results are drained; each result is registered: the transfer edge updates the
// cell row and sets a pending flag, and the output register is loaded from the
// row once it is free. Clear, append and begin-text each restart the text. No
// clearing pass is needed after reset.
module wildcard_star_regex_matcher (
	input  logic                clk,
	input  logic                arst_n,
	input  wcsm_pkg::item_t     item,
	input  logic                item_valid,
	output logic                item_stall,
	output wcsm_pkg::result_t   result,
	output logic                result_valid,
	input  logic                result_stall
);

	localparam int unsigned PM = wcsm_pkg::PATTERN_MAX;
	localparam int unsigned LW = wcsm_pkg::LEN_W;

	logic [LW-1:0]     len_q;
	logic              raw_end_q;
	logic              pending_q;
	logic              ovf_q;
	logic              result_valid_q;
	wcsm_pkg::result_t result_q;

	logic              accept;
	logic              load;
	logic              is_append;
	logic              room;
	logic              app_ok;
	wcsm_pkg::bcast_t  bcast;

	logic [PM-1:0]     start_w;
	logic [PM-1:0]     skip_w;
	logic [PM-1:0]     adv_w;
	logic [PM:0]       closed_all;
	logic              skip_end;

	assign load = pending_q & (~result_valid_q | ~result_stall);
	assign item_stall = pending_q & ~load;
	assign accept = item_valid & ~item_stall;

	assign is_append = (item.opcode == wcsm_pkg::OP_APPEND);
	assign room = (len_q < LW'(PM));
	assign app_ok = accept & is_append & room;

	assign bcast.restart = accept & (item.opcode != wcsm_pkg::OP_TEXT);
	assign bcast.consume = accept & (item.opcode == wcsm_pkg::OP_TEXT);
	assign bcast.data_byte = item.data_byte;

	for (genvar j = 0; j < PM; j++) begin : g_cell
		localparam int unsigned IDX = j;
		localparam int unsigned IDX1 = j + 1;
		wcsm_pkg::cell_ctl_t ctl;
		logic prev_start;
		logic skip_in;
		logic adv_in;

		assign ctl.origin = (IDX == 0);
		assign ctl.live = (len_q > IDX[LW-1:0]);
		assign ctl.live_next = (len_q > IDX1[LW-1:0]);
		assign ctl.wr = app_ok & (len_q == IDX[LW-1:0]);
		assign ctl.nxt_wr = app_ok & (len_q == IDX1[LW-1:0]);

		if (j == 0) begin : g_first
			assign prev_start = 1'b0;
			assign adv_in = 1'b0;
		end else begin : g_rest
			assign prev_start = start_w[j-1];
			assign adv_in = adv_w[j-1];
		end

		if (j < 2) begin : g_noskip
			assign skip_in = 1'b0;
		end else begin : g_skip
			assign skip_in = skip_w[j-2];
		end

		wcsm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.bcast      (bcast),
			.ctl        (ctl),
			.prev_start (prev_start),
			.skip_in    (skip_in),
			.adv_in     (adv_in),
			.start      (start_w[j]),
			.skip_out   (skip_w[j]),
			.adv_out    (adv_w[j]),
			.closed     (closed_all[j])
		);
	end

	// Active bit of the position just past a full store.
	if (PM >= 2) begin : g_end_skip
		assign skip_end = skip_w[PM-2];
	end else begin : g_end_noskip
		assign skip_end = 1'b0;
	end

	assign closed_all[PM] = raw_end_q | skip_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			raw_end_q <= 1'b0;
			pending_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept && item.opcode == wcsm_pkg::OP_CLEAR) begin
				len_q <= '0;
			end else if (app_ok) begin
				len_q <= len_q + LW'(1);
			end

			if (bcast.restart) begin
				raw_end_q <= 1'b0;
			end else if (bcast.consume) begin
				raw_end_q <= adv_w[PM-1];
			end

			if (accept) begin
				pending_q <= 1'b1;
			end else if (load) begin
				pending_q <= 1'b0;
			end

			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The cell row already holds the pending item's state when it is loaded.
	always_ff @(posedge clk) begin
		if (accept) begin
			ovf_q <= is_append & ~room;
		end
		if (load) begin
			result_q.matched <= closed_all[len_q];
			result_q.overflow <= ovf_q;
		end
	end

	assign result = result_q;
	assign result_valid = result_valid_q;

endmodule

### rtl/wcsm_checker.sv
// Port-level checker for the matcher and its bind to the top level.
`include "wildcard_star_regex_matcher_assert.svh"

module wcsm_checker (
	input logic              clk,
	input logic              arst_n,
	input wcsm_pkg::item_t   item,
	input logic              item_valid,
	input logic              item_stall,
	input wcsm_pkg::result_t result,
	input logic              result_valid,
	input logic              result_stall
);

	logic in_xfer;
	logic out_held;
	logic clr_xfer;
	logic other_xfer;
	logic empty_ok;
	logic no_ovf;

	assign in_xfer = item_valid & ~item_stall;
	assign out_held = result_valid & result_stall;
	assign clr_xfer = in_xfer & (item.opcode == wcsm_pkg::OP_CLEAR);
	assign other_xfer = in_xfer & (item.opcode != wcsm_pkg::OP_APPEND);
	assign empty_ok = result_valid & result.matched & ~result.overflow;
	assign no_ovf = result_valid & ~result.overflow;

	`WCSM_ASSERT_NEXT(a_result_hold, out_held, result_valid && $stable(result), "result changed")

	// The input side backs up only behind a stalled result.
	`WCSM_ASSERT_NOW(a_stall_cause, item_stall, out_held, "input stalled while output free")

	// An empty pattern matches the empty text, and a clear drops nothing.
	`WCSM_ASSERT_NEXT(a_clear_result, clr_xfer ##1 !result_valid, empty_ok, "no empty match")

	`WCSM_ASSERT_NEXT(a_ovf_append, other_xfer ##1 !result_valid, no_ovf, "overflow, no append")

endmodule

bind wildcard_star_regex_matcher wcsm_checker u_wcsm_checker (.*);
